// ===== sv/multi_pin_debounce_edge_detect_assert.svh =====
// Assertion macros for the multi-pin debouncer; empty when synthesising.
`ifndef MULTI_PIN_DEBOUNCE_EDGE_DETECT_ASSERT_SVH
`define MULTI_PIN_DEBOUNCE_EDGE_DETECT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define MPDB_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("mpdb assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define MPDB_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("mpdb assertion failed");
`else
`define MPDB_ASSERT_NOW(lbl, pre, post)
`define MPDB_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== sv/mpdb_pkg.sv =====
// Shared types and constants of the multi-pin debouncer.
package mpdb_pkg;

	localparam int PIN_W   = 4;
	localparam int UPPER_W = 10;
	localparam int LOWER_W = 11;
	localparam int INTEG_W = 11;
	localparam int DATA_W  = 8;
	localparam int CFG_W   = 11;

	// configuration register indexes
	localparam logic CFG_UPPER = 1'b0;
	localparam logic CFG_LOWER = 1'b1;

	localparam logic [UPPER_W-1:0]        UPPER_RST = 10'd512;
	localparam logic signed [LOWER_W-1:0] LOWER_RST = -11'sd512;

	typedef logic [UPPER_W-1:0]        upper_t;
	typedef logic signed [LOWER_W-1:0] lower_t;
	typedef logic signed [INTEG_W-1:0] integ_t;

	// outcome of one per-pin update
	typedef struct packed {
		logic   decide;    // a level decision was made
		logic   dec_val;   // decided level
		logic   emit;      // decision differs from stored level
		integ_t integ_nxt; // integrator value to write back
	} upd_t;

endpackage

// ===== sv/mpdb_update.sv =====
// Per-pin integrator step: count, compare against limits, detect an edge.
module mpdb_update (
	input  mpdb_pkg::integ_t integ,
	input  logic             level,
	input  logic             stored,
	input  mpdb_pkg::upper_t upper,
	input  mpdb_pkg::lower_t lower,
	output mpdb_pkg::upd_t   upd
);
	import mpdb_pkg::*;

	// one bit of headroom so the sum never wraps
	logic signed [INTEG_W:0] sum;
	logic signed [INTEG_W:0] up_x;
	logic signed [INTEG_W:0] lo_x;
	logic                    hi_dec;
	logic                    lo_dec;

	always_comb begin
		up_x   = $signed({2'b00, upper});
		lo_x   = {lower[LOWER_W-1], lower};
		sum    = {integ[INTEG_W-1], integ} + (level ? 12'sd1 : -12'sd1);
		hi_dec = level && (sum > up_x);
		lo_dec = !hi_dec && (sum <= lo_x);

		upd.decide    = hi_dec || lo_dec;
		upd.dec_val   = hi_dec;
		upd.emit      = upd.decide && (hi_dec != stored);
		upd.integ_nxt = upd.decide ? '0 : sum[INTEG_W-1:0];
	end

endmodule

// ===== sv/multi_pin_debounce_edge_detect.sv =====
// Top level of the multi-pin up/down debouncer with edge events.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------
//  s_*     | in  | s_tvalid / s_tready   | tdata: pin_index[3:0], level[4]
//  m_*     | out | m_tvalid / m_tready   | tdata: event_pin[3:0]; tuser: edge
//  cfg_*   | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while the event register is not blocked; an
// event passes through stage s1 and then the event register before m_tvalid.
// Stage s1 holds the sample and the integrator read; the pin state is
// written back in the same cycle, with a bypass when the next beat hits the
// same pin. Integrator storage has per-entry valid bits, so no clearing pass.
// Input stalls only when s1 holds a sample and the event register is full
// and not being taken. Reset is asynchronous, restores the default limits
// and clears levels, valid bits and stage flags.
`include "multi_pin_debounce_edge_detect_assert.svh"

module multi_pin_debounce_edge_detect #(
	parameter int PIN_COUNT = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// slave stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [mpdb_pkg::DATA_W-1:0] s_tdata,  // [3:0] pin_index, [4] level, rest zero
	// master stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [mpdb_pkg::DATA_W-1:0] m_tdata,  // [3:0] event_pin, rest zero
	output logic                       m_tuser,  // [0] edge_res, 1 rising 0 falling
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [mpdb_pkg::CFG_W-1:0] cfg_data
);
	import mpdb_pkg::*;

	localparam int IDX_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
	localparam logic [8:0] PIN_LIM = 9'(PIN_COUNT);

	// limits
	upper_t upper_q;
	lower_t lower_q;

	// per-pin state
	integ_t               integ_mem [PIN_COUNT];
	logic [PIN_COUNT-1:0] ivalid_q;
	logic [PIN_COUNT-1:0] lvl_q;

	// stage 1
	logic             valid_s1;
	logic             range_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [PIN_W-1:0] pin_s1;
	logic             level_s1;
	integ_t           integ_s1;

	// event register
	logic             m_valid_q;
	logic [PIN_W-1:0] ev_pin_q;
	logic             ev_edge_q;

	logic             in_acc;
	logic             s1_go;
	logic [8:0]       pin_ext;
	logic [IDX_W-1:0] in_idx;
	logic             in_range;
	logic             fwd;
	integ_t           rd_integ;
	upd_t             upd;

	// config: always ready; only write while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UPPER_RST;
			lower_q <= LOWER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_UPPER: upper_q <= cfg_data[UPPER_W-1:0];
				CFG_LOWER: lower_q <= cfg_data;
				default:   upper_q <= upper_q;
			endcase
		end
	end

	// s1 moves on whenever the event register is free or draining
	assign s1_go    = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_go;
	assign in_acc   = s_tvalid && s_tready;

	assign pin_ext  = {5'b0, s_tdata[PIN_W-1:0]};
	assign in_idx   = pin_ext[IDX_W-1:0];
	assign in_range = pin_ext < PIN_LIM;

	// bypass the write-back that lands on the same edge as the read
	assign fwd = s1_go && range_s1 && (idx_s1 == in_idx);

	always_comb begin
		if (fwd)
			rd_integ = upd.integ_nxt;
		else if (ivalid_q[in_idx])
			rd_integ = integ_mem[in_idx];
		else
			rd_integ = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			range_s1 <= in_range;
			idx_s1   <= in_idx;
			pin_s1   <= s_tdata[PIN_W-1:0];
			level_s1 <= s_tdata[PIN_W];
			integ_s1 <= rd_integ;
		end
	end

	mpdb_update u_update (
		.integ  (integ_s1),
		.level  (level_s1),
		.stored (lvl_q[idx_s1]),
		.upper  (upper_q),
		.lower  (lower_q),
		.upd    (upd)
	);

	// write-back of integrator (no reset, covered by valid bits)
	always_ff @(posedge clk) begin
		if (s1_go && range_s1)
			integ_mem[idx_s1] <= upd.integ_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ivalid_q <= '0;
			lvl_q    <= '0;
		end else if (s1_go && range_s1) begin
			ivalid_q[idx_s1] <= 1'b1;
			if (upd.emit)
				lvl_q[idx_s1] <= upd.dec_val;
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_go) begin
			m_valid_q <= range_s1 && upd.emit;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && range_s1 && upd.emit) begin
			ev_pin_q  <= pin_s1;
			ev_edge_q <= upd.dec_val;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(DATA_W-PIN_W){1'b0}}, ev_pin_q};
	assign m_tuser  = ev_edge_q;

	// an edge always comes from a decision
	`MPDB_ASSERT_NOW(a_emit_decide, valid_s1 && upd.emit, upd.decide)
	// an emitted event shows up on the master side next cycle
	`MPDB_ASSERT_NEXT(a_emit_out, s1_go && range_s1 && upd.emit, m_tvalid)
	// a held sample behind a blocked event register back-pressures input
	`MPDB_ASSERT_NOW(a_stall, valid_s1 && m_valid_q && !m_tready, !s_tready)

endmodule
